@@ rtl/binary128_add_sub_mul_div_core_macros.svh @@
// ------------------------------------------------------------------------
// binary128_add_sub_mul_div_core_macros
// assertion macros shared by the binary128 arithmetic core
// ------------------------------------------------------------------------
`ifndef BINARY128_ADD_SUB_MUL_DIV_CORE_MACROS_SVH
`define BINARY128_ADD_SUB_MUL_DIV_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define B128ASMD_ASSERT_NOW(lbl, trig, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("b128asmd check failed");
// next-cycle implication
`define B128ASMD_ASSERT_NEXT(lbl, trig, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("b128asmd check failed");
`else
`define B128ASMD_ASSERT_NOW(lbl, trig, cond)
`define B128ASMD_ASSERT_NEXT(lbl, trig, cond)
`endif

`endif

@@ rtl/b128asmd_pkg.sv @@
// ------------------------------------------------------------------------
// b128asmd_pkg
// types and constants of the binary128 arithmetic core
// ------------------------------------------------------------------------
package b128asmd_pkg;

   localparam int ExpMax        = (1 << 15) - 1;
   localparam int ExpBias       = (1 << 14) - 1;
   localparam int SigBits       = 113;
   localparam int FracBits      = 32 * 3 + 16;
   localparam int DivErrPayload = 404;
   localparam int MulGuard      = 127 - SigBits;
   localparam int WordW         = 128;
   localparam int ExW           = 18;

   typedef enum logic [1:0] {
      ACT_ADD = 2'd0,
      ACT_SUB = 2'd1,
      ACT_MUL = 2'd2,
      ACT_DIV = 2'd3
   } action_type;

   typedef enum logic [14:0] {
      ST_IDLE   = 15'b000000000000001,
      ST_ALIGN  = 15'b000000000000010,
      ST_ADDSUB = 15'b000000000000100,
      ST_NORM   = 15'b000000000001000,
      ST_MSWAP  = 15'b000000000010000,
      ST_MUL    = 15'b000000000100000,
      ST_MNORM0 = 15'b000000001000000,
      ST_MNORM  = 15'b000000010000000,
      ST_MPOST  = 15'b000000100000000,
      ST_DNB    = 15'b000001000000000,
      ST_DNA    = 15'b000010000000000,
      ST_DIV    = 15'b000100000000000,
      ST_DFIX   = 15'b001000000000000,
      ST_DSHIFT = 15'b010000000000000,
      ST_DONE   = 15'b100000000000000
   } state_type;

endpackage

@@ rtl/b128asmd_req_if.sv @@
// ------------------------------------------------------------------------
// b128asmd_req_if
// request channel: opcode and two binary128 operands
// ------------------------------------------------------------------------
interface b128asmd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic        a_sign;
   logic [14:0] a_exponent;
   logic [47:0] a_frac_high;
   logic [63:0] a_frac_low;
   logic        b_sign;
   logic [14:0] b_exponent;
   logic [47:0] b_frac_high;
   logic [63:0] b_frac_low;

   modport source (output valid, action, a_sign, a_exponent, a_frac_high, a_frac_low,
                   b_sign, b_exponent, b_frac_high, b_frac_low, input ready);
   modport sink   (input valid, action, a_sign, a_exponent, a_frac_high, a_frac_low,
                   b_sign, b_exponent, b_frac_high, b_frac_low, output ready);
endinterface

@@ rtl/b128asmd_rsp_if.sv @@
// ------------------------------------------------------------------------
// b128asmd_rsp_if
// response channel: binary128 result and divide-by-zero flag
// ------------------------------------------------------------------------
interface b128asmd_rsp_if;
   logic        valid;
   logic        ready;
   logic        res_sign;
   logic [14:0] res_exponent;
   logic [47:0] res_frac_high;
   logic [63:0] res_frac_low;
   logic        div_by_zero;

   modport source (output valid, res_sign, res_exponent, res_frac_high, res_frac_low,
                   div_by_zero, input ready);
   modport sink   (input valid, res_sign, res_exponent, res_frac_high, res_frac_low,
                   div_by_zero, output ready);
endinterface

@@ rtl/b128asmd_alu.sv @@
// ------------------------------------------------------------------------
// b128asmd_alu
// shared 128-bit adder / subtractor, carry out doubles as a >= b
// ------------------------------------------------------------------------
module b128asmd_alu (
   input  logic [b128asmd_pkg::WordW-1:0] op_a,
   input  logic [b128asmd_pkg::WordW-1:0] op_b,
   input  logic                           op_sub,
   output logic [b128asmd_pkg::WordW:0]   result
);

   logic [b128asmd_pkg::WordW-1:0] b_eff;

   assign b_eff  = op_sub ? ~op_b : op_b;
   // for subtract the top bit is set when there was no borrow
   assign result = {1'b0, op_a} + {1'b0, b_eff}
                 + {{b128asmd_pkg::WordW{1'b0}}, op_sub};

endmodule

@@ rtl/binary128_add_sub_mul_div_core.sv @@
// ------------------------------------------------------------------------
// binary128_add_sub_mul_div_core
// truncating binary128 add, subtract, multiply and divide
// ------------------------------------------------------------------------
// one transaction on req_chan carries an opcode and two binary128 operands,
// and produces exactly one transaction on rsp_chan. all arithmetic runs on a
// single shared 128-bit adder/subtractor stepped by a small sequencer, so
// req_chan.ready is high only while the sequencer is idle. zero operands and
// divide by zero go straight to the done state; add/subtract finishes in the
// align state when the smaller operand shifts away, in the add/subtract
// state for equal signs, and otherwise swaps the operands when the second
// magnitude is larger, subtracts, then normalizes with single-bit left
// shifts after cancellation; multiply runs the 113 shift-and-add steps,
// then normalization and wrap-up; divide normalizes each significand by its
// leading zeros, runs the 113 restoring steps, adds at most one extra
// quotient bit and then the denormalization shift. the 113-step multiply
// and divide loops on the shared adder set the rate. a finished result sits
// in an output register until taken; the sequencer holds in its done state
// while that register is still full and rsp_chan.ready is low.
`include "binary128_add_sub_mul_div_core_macros.svh"

module binary128_add_sub_mul_div_core (
   input  logic          clock,
   input  logic          reset,
   b128asmd_req_if.sink   req_chan,
   b128asmd_rsp_if.source rsp_chan
);

   localparam int W   = b128asmd_pkg::WordW;
   localparam int EW  = b128asmd_pkg::ExW;
   localparam int SB  = b128asmd_pkg::SigBits;
   localparam int FB  = b128asmd_pkg::FracBits;
   localparam int MG  = b128asmd_pkg::MulGuard;

   localparam logic signed [EW-1:0] ExMax   = EW'(b128asmd_pkg::ExpMax);
   localparam logic signed [EW-1:0] ExMaxM1 = EW'(b128asmd_pkg::ExpMax - 1);
   localparam logic signed [EW-1:0] ExBias  = EW'(b128asmd_pkg::ExpBias);
   localparam logic signed [EW-1:0] ExOne   = EW'(1);
   localparam logic signed [EW-1:0] ExZero  = '0;
   localparam logic [6:0] CntSigLast  = 7'(SB - 1);
   localparam logic [6:0] CntFracLast = 7'(FB - 1);

   // sequencer and datapath registers
   b128asmd_pkg::state_type state_ff, state_in;
   logic [W-1:0]         x_ff, x_in;
   logic [W-1:0]         y_ff, y_in;
   logic [W-1:0]         acc_ff, acc_in;
   logic signed [EW-1:0] ex_ff, ex_in;
   logic [6:0]           cnt_ff, cnt_in;
   logic                 sa_ff, sa_in;
   logic                 sb_ff, sb_in;
   logic [14:0]          ea_ff, ea_in;
   logic [14:0]          eb_ff, eb_in;
   logic                 dz_ff, dz_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        o_sign_ff, o_sign_in;
   logic [14:0] o_exp_ff, o_exp_in;
   logic [FB-1:0] o_frac_ff, o_frac_in;
   logic        o_dz_ff, o_dz_in;

   // shared units
   logic [W-1:0]   alu_a, alu_b;
   logic           alu_sub;
   logic [W:0]     alu_res;
   logic [W-1:0]   shf_val, shf_out;
   logic [EW-1:0]  shf_amt;

   // operand decode
   logic [SB-1:0]  na, nb;
   logic           za, zb;
   logic [14:0]    e1, e2, re1, re2;

   // finish request
   logic           fin_go;
   logic           fin_sign;
   logic [14:0]    fin_exp;
   logic [FB-1:0]  fin_frac;
   logic           fin_dz;

   logic           ge;
   logic [W-1:0]   sum_r, mul_adj;
   logic signed [EW-1:0] ex_nx;
   logic                 take;

   b128asmd_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .op_sub (alu_sub),
      .result (alu_res)
   );

   assign na  = {|req_chan.a_exponent, req_chan.a_frac_high, req_chan.a_frac_low};
   assign nb  = {|req_chan.b_exponent, req_chan.b_frac_high, req_chan.b_frac_low};
   assign za  = ~|na;
   assign zb  = ~|nb;
   // subnormal exponents read as one
   assign re1 = (req_chan.a_exponent == '0) ? 15'd1 : req_chan.a_exponent;
   assign re2 = (req_chan.b_exponent == '0) ? 15'd1 : req_chan.b_exponent;
   assign e1  = (ea_ff == '0) ? 15'd1 : ea_ff;
   assign e2  = (eb_ff == '0) ? 15'd1 : eb_ff;

   // barrel right shift, everything lost at 128 places or more
   assign shf_out = (shf_amt >= EW'(W)) ? '0 : (shf_val >> shf_amt[6:0]);

   // shared unit operand selection
   always_comb begin
      alu_a   = x_ff;
      alu_b   = y_ff;
      alu_sub = 1'b1;
      shf_val = acc_ff;
      shf_amt = '0;
      unique case (state_ff)
         b128asmd_pkg::ST_ALIGN: begin
            if (e1 > e2) begin
               shf_val = y_ff;
               shf_amt = EW'(e1 - e2);
            end else begin
               shf_val = x_ff;
               shf_amt = EW'(e2 - e1);
            end
         end
         b128asmd_pkg::ST_ADDSUB: alu_sub = (sa_ff != sb_ff);
         b128asmd_pkg::ST_MUL: begin
            alu_a   = acc_ff;
            alu_b   = x_ff;
            alu_sub = 1'b0;
         end
         b128asmd_pkg::ST_DSHIFT: begin
            // quotient denormalization shift
            shf_amt = EW'(ExOne - ex_ff);
         end
         default: ;
      endcase
   end

   assign ge    = alu_res[W];
   assign sum_r = alu_res[W-1:0];
   assign ex_nx = ex_ff - ExOne;
   assign mul_adj = (ex_ff == ExZero && acc_ff[W-2]) ? (acc_ff >> 1) : acc_ff;
   assign take  = !rsp_valid_ff || rsp_chan.ready;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      acc_in    = acc_ff;
      ex_in     = ex_ff;
      cnt_in    = cnt_ff;
      sa_in     = sa_ff;
      sb_in     = sb_ff;
      ea_in     = ea_ff;
      eb_in     = eb_ff;
      dz_in     = dz_ff;
      fin_go    = 1'b0;
      fin_sign  = 1'b0;
      fin_exp   = '0;
      fin_frac  = '0;
      fin_dz    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      o_sign_in = o_sign_ff;
      o_exp_in  = o_exp_ff;
      o_frac_in = o_frac_ff;
      o_dz_in   = o_dz_ff;

      unique case (state_ff)
         b128asmd_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               x_in  = W'(na);
               y_in  = W'(nb);
               sa_in = req_chan.a_sign;
               sb_in = req_chan.b_sign ^
                       (req_chan.action == b128asmd_pkg::ACT_SUB);
               ea_in = req_chan.a_exponent;
               eb_in = req_chan.b_exponent;
               dz_in = 1'b0;
               unique case (req_chan.action)
                  b128asmd_pkg::ACT_ADD, b128asmd_pkg::ACT_SUB: begin
                     // a zero operand passes the other through, b negated for subtract
                     if (za) begin
                        fin_go   = 1'b1;
                        fin_sign = sb_in;
                        fin_exp  = req_chan.b_exponent;
                        fin_frac = nb[FB-1:0];
                     end else if (zb) begin
                        fin_go   = 1'b1;
                        fin_sign = req_chan.a_sign;
                        fin_exp  = req_chan.a_exponent;
                        fin_frac = na[FB-1:0];
                     end else begin
                        state_in = b128asmd_pkg::ST_ALIGN;
                     end
                  end
                  b128asmd_pkg::ACT_MUL: begin
                     if (za || zb) begin
                        fin_go = 1'b1;
                     end else begin
                        ex_in    = EW'(re1) + EW'(re2) - ExBias;
                        x_in     = {1'b0, na, {MG{1'b0}}};
                        y_in     = {1'b0, nb, {MG{1'b0}}};
                        state_in = b128asmd_pkg::ST_MSWAP;
                     end
                  end
                  default: begin
                     if (zb) begin
                        fin_go   = 1'b1;
                        fin_exp  = 15'(b128asmd_pkg::ExpMax);
                        fin_frac = FB'(b128asmd_pkg::DivErrPayload);
                        fin_dz   = 1'b1;
                     end else if (za) begin
                        fin_go = 1'b1;
                     end else begin
                        ex_in    = ExBias + EW'(re1) - EW'(re2);
                        state_in = b128asmd_pkg::ST_DNB;
                     end
                  end
               endcase
            end
         end

         b128asmd_pkg::ST_ALIGN: begin
            state_in = b128asmd_pkg::ST_ADDSUB;
            if (e1 > e2) begin
               y_in  = shf_out;
               ex_in = EW'(e1);
               if (shf_out == '0) begin
                  fin_go   = 1'b1;
                  fin_sign = sa_ff;
                  fin_exp  = ea_ff;
                  fin_frac = x_ff[FB-1:0];
               end
            end else if (e1 < e2) begin
               x_in  = shf_out;
               ex_in = EW'(e2);
               if (shf_out == '0) begin
                  fin_go   = 1'b1;
                  fin_sign = sb_ff;
                  fin_exp  = eb_ff;
                  fin_frac = y_ff[FB-1:0];
               end
            end else begin
               ex_in = EW'(e1);
            end
         end

         b128asmd_pkg::ST_ADDSUB: begin
            if (sa_ff == sb_ff) begin
               fin_go   = 1'b1;
               fin_sign = sa_ff;
               if (sum_r[SB]) begin
                  // carry out: renormalize right, may overflow to infinity
                  if (ex_ff + ExOne > ExMaxM1) begin
                     fin_exp = 15'(b128asmd_pkg::ExpMax);
                  end else begin
                     fin_exp  = 15'(ex_ff + ExOne);
                     fin_frac = sum_r[FB:1];
                  end
               end else if (ex_ff == ExOne && !sum_r[FB]) begin
                  fin_frac = sum_r[FB-1:0];
               end else begin
                  fin_exp  = ex_ff[14:0];
                  fin_frac = sum_r[FB-1:0];
               end
            end else if (!ge) begin
               // second magnitude larger: swap and retry
               x_in  = y_ff;
               y_in  = x_ff;
               sa_in = sb_ff;
               sb_in = sa_ff;
            end else begin
               acc_in   = sum_r;
               state_in = b128asmd_pkg::ST_NORM;
            end
         end

         b128asmd_pkg::ST_NORM: begin
            if (acc_ff != '0 && !acc_ff[FB] && ex_ff > ExOne) begin
               acc_in = acc_ff << 1;
               ex_in  = ex_nx;
            end else begin
               fin_go = 1'b1;
               if (acc_ff != '0) begin
                  fin_sign = sa_ff;
                  fin_exp  = acc_ff[FB] ? ex_ff[14:0] : '0;
                  fin_frac = acc_ff[FB-1:0];
               end
            end
         end

         b128asmd_pkg::ST_MSWAP: begin
            if (!ge) begin
               x_in = y_ff;
               y_in = x_ff;
            end
            acc_in   = '0;
            cnt_in   = '0;
            state_in = b128asmd_pkg::ST_MUL;
         end

         b128asmd_pkg::ST_MUL: begin
            if (y_ff[W-2]) acc_in = sum_r;
            x_in   = x_ff >> 1;
            y_in   = y_ff << 1;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == CntSigLast) state_in = b128asmd_pkg::ST_MNORM0;
         end

         b128asmd_pkg::ST_MNORM0: begin
            if (acc_ff[W-1]) begin
               ex_in    = ex_ff + ExOne;
               acc_in   = acc_ff >> 1;
               state_in = b128asmd_pkg::ST_MPOST;
            end else begin
               cnt_in   = '0;
               state_in = b128asmd_pkg::ST_MNORM;
            end
         end

         b128asmd_pkg::ST_MNORM: begin
            if (acc_ff[W-2]) begin
               state_in = b128asmd_pkg::ST_MPOST;
            end else begin
               acc_in = acc_ff << 1;
               ex_in  = ex_nx;
               cnt_in = cnt_ff + 7'd1;
               if (ex_nx < ExZero) begin
                  state_in = b128asmd_pkg::ST_MPOST;
               end else if (ex_nx == ExZero) begin
                  // landing on exponent zero undoes this shift
                  acc_in   = acc_ff;
                  state_in = b128asmd_pkg::ST_MPOST;
               end else if (cnt_ff == CntFracLast) begin
                  state_in = b128asmd_pkg::ST_MPOST;
               end
            end
         end

         b128asmd_pkg::ST_MPOST: begin
            fin_go = 1'b1;
            if (ex_ff > ExMaxM1) begin
               fin_sign = sa_ff ^ sb_ff;
               fin_exp  = 15'(b128asmd_pkg::ExpMax);
            end else if (ex_ff >= ExZero) begin
               fin_sign = sa_ff ^ sb_ff;
               fin_exp  = ex_ff[14:0];
               fin_frac = mul_adj[FB+MG-1:MG];
            end
         end

         b128asmd_pkg::ST_DNB: begin
            if (!y_ff[FB]) begin
               y_in  = y_ff << 1;
               ex_in = ex_ff + ExOne;
            end else begin
               state_in = b128asmd_pkg::ST_DNA;
            end
         end

         b128asmd_pkg::ST_DNA: begin
            if (!x_ff[FB]) begin
               x_in  = x_ff << 1;
               ex_in = ex_nx;
            end else begin
               acc_in   = '0;
               cnt_in   = '0;
               state_in = b128asmd_pkg::ST_DIV;
            end
         end

         b128asmd_pkg::ST_DIV: begin
            // one restoring quotient bit per cycle
            acc_in = {acc_ff[W-2:0], ge};
            x_in   = (ge ? sum_r : x_ff) << 1;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == CntSigLast) state_in = b128asmd_pkg::ST_DFIX;
         end

         b128asmd_pkg::ST_DFIX: begin
            if (ex_ff > ExZero && !acc_ff[FB]) begin
               acc_in = {acc_ff[W-2:0], ge};
               x_in   = (ge ? sum_r : x_ff) << 1;
               ex_in  = ex_nx;
            end else begin
               state_in = b128asmd_pkg::ST_DSHIFT;
            end
         end

         b128asmd_pkg::ST_DSHIFT: begin
            fin_go = 1'b1;
            if (ex_ff <= ExZero) begin
               fin_sign = sa_ff ^ sb_ff;
               fin_frac = shf_out[FB-1:0];
            end else if (ex_ff >= ExMax) begin
               fin_exp = 15'(b128asmd_pkg::ExpMax);
            end else begin
               fin_sign = sa_ff ^ sb_ff;
               fin_exp  = ex_ff[14:0];
               fin_frac = acc_ff[FB-1:0];
            end
         end

         default: begin
            // done: move the result into the output register once it is free
            if (take) begin
               rsp_valid_in = 1'b1;
               o_sign_in    = sa_ff;
               o_exp_in     = ea_ff;
               o_frac_in    = acc_ff[FB-1:0];
               o_dz_in      = dz_ff;
               state_in     = b128asmd_pkg::ST_IDLE;
            end
         end
      endcase

      if (fin_go) begin
         acc_in   = W'(fin_frac);
         sa_in    = fin_sign;
         ea_in    = fin_exp;
         dz_in    = fin_dz;
         state_in = b128asmd_pkg::ST_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= b128asmd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      acc_ff    <= acc_in;
      ex_ff     <= ex_in;
      cnt_ff    <= cnt_in;
      sa_ff     <= sa_in;
      sb_ff     <= sb_in;
      ea_ff     <= ea_in;
      eb_ff     <= eb_in;
      dz_ff     <= dz_in;
      o_sign_ff <= o_sign_in;
      o_exp_ff  <= o_exp_in;
      o_frac_ff <= o_frac_in;
      o_dz_ff   <= o_dz_in;
   end

   assign req_chan.ready         = (state_ff == b128asmd_pkg::ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.res_sign      = o_sign_ff;
   assign rsp_chan.res_exponent  = o_exp_ff;
   assign rsp_chan.res_frac_high = o_frac_ff[FB-1:64];
   assign rsp_chan.res_frac_low  = o_frac_ff[63:0];
   assign rsp_chan.div_by_zero   = o_dz_ff;

   // an accepted transaction always leaves the sequencer busy
   `B128ASMD_ASSERT_NEXT(a_busy_after_accept, req_chan.valid && req_chan.ready, !req_chan.ready)
   // divide-by-zero results are always the positive error pattern
   `B128ASMD_ASSERT_NOW(a_dz_pattern, rsp_chan.valid && rsp_chan.div_by_zero,
      rsp_chan.res_exponent == 15'(b128asmd_pkg::ExpMax) && !rsp_chan.res_sign)
   // a result never lands in an output register that is still full
   `B128ASMD_ASSERT_NEXT(a_no_overwrite, rsp_chan.valid && !rsp_chan.ready,
      rsp_chan.valid && $stable(rsp_chan.res_frac_low))

endmodule
